### sv/command_frame_builder_crc16_defines.svh
// Assertion macros shared by the frame builder.
`ifndef COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication, checked on every rising clock edge out of reset.
`define CFB_ASSERT_LATER2(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### sv/cfb_pkg.sv
package cfb_pkg;

    // Frame layout.
    localparam int FRAME_LEN = 18;
    localparam int BODY_LEN  = 16;

    typedef logic [4:0] idx_t;
    typedef logic [7:0] byte_t;
    typedef logic [15:0] crc_t;

    localparam idx_t HDR_IDX     = 5'd0;
    localparam idx_t MODE_IDX    = 5'd7;
    localparam idx_t CMD_IDX     = 5'd8;
    localparam idx_t TAIL_IDX    = 5'd15;
    localparam idx_t CRC_HI_IDX  = 5'(BODY_LEN);
    localparam idx_t LAST_IDX    = 5'(FRAME_LEN - 1);

    localparam byte_t HDR_BYTE  = 8'h86;
    localparam byte_t TAIL_BYTE = 8'h01;
    localparam crc_t  CRC_POLY  = 16'h1201;

endpackage

### sv/command_frame_builder_crc16.sv
// Channel   | Signals                                  | Handshake
// ----------+------------------------------------------+---------------------------
// request   | mode_byte, command_byte                  | start && !busy at clk edge
// result    | frame_byte, byte_index, last_byte        | strobe, one cycle per byte
// config    | cfg_data (serial number)                 | cfg_write at clk edge
//
// Each request yields 18 result bytes on consecutive cycles: the request is
// registered in the byte counter, then each byte in the output registers.
// busy drops during the cycle that produces the last byte, so that frames
// follow without a gap. The CRC is built one byte per cycle as the body
// bytes go out. rst_n clears the serial number, the byte counter and the
// strobe. The receiver cannot stall.
module command_frame_builder_crc16
    import cfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  mode_byte,
    input  logic [7:0]  command_byte,
    input  logic        cfg_write,
    input  logic [47:0] cfg_data,
    output logic        strobe,
    output logic [7:0]  frame_byte,
    output logic [4:0]  byte_index,
    output logic        last_byte
);

`include "command_frame_builder_crc16_defines.svh"

    logic [47:0] serial_reg;
    logic [47:0] frame_serial_reg;
    byte_t       mode_reg;
    byte_t       cmd_reg;
    logic        active_reg;
    logic        active_next;
    idx_t        idx_reg;
    idx_t        idx_next;
    crc_t        crc_reg;
    crc_t        crc_next;
    crc_t        crc_step;
    byte_t       cur_byte;
    logic        accept;

    logic        strobe_reg;
    byte_t       out_byte_reg;
    idx_t        out_idx_reg;
    logic        out_last_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg <= '0;
        end
        else if (cfg_write)
        begin
            serial_reg <= cfg_data;
        end
    end

    // A new request is taken while idle or once the frame in flight is on its last byte.
    assign busy   = active_reg && (idx_reg != LAST_IDX);
    assign accept = start && !busy;

    // Select the frame byte for the current position.
    always_comb
    begin
        case (idx_reg)
            HDR_IDX:    cur_byte = HDR_BYTE;
            5'd1:       cur_byte = frame_serial_reg[47:40];
            5'd2:       cur_byte = frame_serial_reg[39:32];
            5'd3:       cur_byte = frame_serial_reg[31:24];
            5'd4:       cur_byte = frame_serial_reg[23:16];
            5'd5:       cur_byte = frame_serial_reg[15:8];
            5'd6:       cur_byte = frame_serial_reg[7:0];
            MODE_IDX:   cur_byte = mode_reg;
            CMD_IDX:    cur_byte = cmd_reg;
            TAIL_IDX:   cur_byte = TAIL_BYTE;
            CRC_HI_IDX: cur_byte = crc_reg[15:8];
            LAST_IDX:   cur_byte = crc_reg[7:0];
            default:    cur_byte = 8'h00;
        endcase
    end

    cfb_crc_step u_crc_step
    (
        .crc_in  (crc_reg),
        .data    (cur_byte),
        .crc_out (crc_step)
    );

    // Counter and CRC control.
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        crc_next    = crc_reg;
        if (accept)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            crc_next    = '0;
        end
        else if (active_reg)
        begin
            if (idx_reg == LAST_IDX)
            begin
                active_next = 1'b0;
            end
            idx_next = idx_reg + 5'd1;
            if (idx_reg < CRC_HI_IDX)
            begin
                crc_next = crc_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= active_reg;
        end
    end

    // Request payload, running CRC and output byte registers; no reset needed.
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (accept)
        begin
            mode_reg         <= mode_byte;
            cmd_reg          <= command_byte;
            frame_serial_reg <= serial_reg;
        end
        out_byte_reg <= cur_byte;
        out_idx_reg  <= idx_reg;
        out_last_reg <= (idx_reg == LAST_IDX);
    end

    assign strobe     = strobe_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign last_byte  = strobe_reg && out_last_reg;

    // Checks on the frame sequencing.
    `CFB_ASSERT_LATER2(a_first_byte, start && !busy, strobe && byte_index == HDR_IDX, "frame did not start with byte zero")
    `CFB_ASSERT_NEXT(a_contiguous, strobe && byte_index != LAST_IDX, strobe && byte_index == $past(byte_index) + 5'd1, "frame bytes not contiguous")
    `CFB_ASSERT_NOW(a_rise_at_head, $rose(strobe), byte_index == HDR_IDX, "result burst began mid-frame")

endmodule

### sv/cfb_crc_step.sv
// One byte of CRC-16 update, MSB first, no reflection.
module cfb_crc_step
    import cfb_pkg::*;
(
    input  crc_t  crc_in,
    input  byte_t data,
    output crc_t  crc_out
);

    // Eight bit steps on a 16-bit value: feed the data into the top byte
    // and shift out one bit at a time.
    always_comb
    begin
        crc_t acc;
        acc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (acc[15])
            begin
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[14:0], 1'b0};
            end
        end
        crc_out = acc;
    end

endmodule
